// ----- rtl/slrf_pkg.sv -----
// Shared types, codes and reply tables for the serial link responder framer.
`timescale 1ns / 1ps
package slrf_pkg;

  localparam logic [1:0] CMD_BYTE    = 2'd0;
  localparam logic [1:0] CMD_REQUEST = 2'd1;
  localparam logic [1:0] CMD_TICK    = 2'd2;

  typedef enum logic [1:0] {
    KIND_HEARTBEAT  = 2'd0,
    KIND_DESCRIPTOR = 2'd1,
    KIND_FRAME      = 2'd2,
    KIND_REFUSED    = 2'd3
  } kind_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] code;
  } job_t;

  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);

  localparam logic [15:0] GAP_RESET = 16'd100;

  localparam logic [7:0] HB_B0   = 8'h60;
  localparam logic [7:0] HB_B1   = 8'h0B;
  localparam logic [7:0] HB_B2   = 8'h6B;
  localparam logic [7:0] DS_B0   = 8'hCD;
  localparam logic [7:0] DS_B1   = 8'hA9;
  localparam logic [7:0] DS_B2   = 8'h00;
  localparam logic [7:0] FRAME_SYNC = 8'hAC;

  function automatic logic [7:0] heartbeat_byte(input logic [1:0] idx);
    logic [7:0] b;
    case (idx)
      2'd0: b = 8'h2C;
      2'd1: b = 8'h01;
      2'd2: b = 8'h99;
      default: b = 8'hEF;
    endcase
    return b;
  endfunction

  function automatic logic [7:0] descriptor_byte(input logic [1:0] idx);
    logic [7:0] b;
    case (idx)
      2'd0: b = 8'h33;
      2'd1: b = 8'h01;
      2'd2: b = 8'h10;
      default: b = 8'h11;
    endcase
    return b;
  endfunction

  function automatic logic [7:0] job_byte(input job_t job, input logic [1:0] idx);
    logic [7:0] b;
    case (job.kind)
      KIND_HEARTBEAT:  b = heartbeat_byte(idx);
      KIND_DESCRIPTOR: b = descriptor_byte(idx);
      KIND_FRAME: begin
        case (idx)
          2'd0: b = FRAME_SYNC;
          2'd1: b = job.code;
          default: b = FRAME_SYNC ^ job.code;
        endcase
      end
      default: b = 8'h00;
    endcase
    return b;
  endfunction

  function automatic logic [1:0] job_last_idx(input kind_t kind);
    logic [1:0] n;
    case (kind)
      KIND_HEARTBEAT:  n = 2'd3;
      KIND_DESCRIPTOR: n = 2'd3;
      KIND_FRAME:      n = 2'd2;
      default:         n = 2'd0;
    endcase
    return n;
  endfunction

endpackage

// ----- rtl/slrf_ifs.sv -----
// Channel interfaces: input items, result items and the configuration write.
`timescale 1ns / 1ps
interface slrf_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] command;
  logic [7:0] rx_byte;
  logic [7:0] camera_code;
  modport source (output valid, command, rx_byte, camera_code, input ready);
  modport sink (input valid, command, rx_byte, camera_code, output ready);
endinterface

interface slrf_rsp_if;
  logic       valid;
  logic       ready;
  logic [7:0] tx_byte;
  logic       last_of_run;
  logic [1:0] result_kind;
  modport source (output valid, tx_byte, last_of_run, result_kind, input ready);
  modport sink (input valid, tx_byte, last_of_run, result_kind, output ready);
endinterface

interface slrf_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

// ----- rtl/slrf_front.sv -----
// Front end: accepts items, runs the byte matchers and the frame gap/hold logic.
`timescale 1ns / 1ps
module slrf_front
  import slrf_pkg::*;
#(
  parameter int GAP_COUNTER_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  slrf_req_if.sink    req,
  input  logic [15:0] min_gap_ticks,
  input  logic        q_full,
  output logic        push,
  output job_t        push_job
);

  localparam int CMP_W = (GAP_COUNTER_BITS > 16) ? GAP_COUNTER_BITS : 16;

  logic [1:0]                  hb_prog, hb_prog_next;
  logic [1:0]                  ds_prog, ds_prog_next;
  logic [GAP_COUNTER_BITS-1:0] ticks, ticks_next, ticks_inc;
  logic                        held_valid, held_valid_next;
  logic [7:0]                  held_code, held_code_next;
  logic                        fire;
  logic                        gap_met, gap_met_inc;
  logic [CMP_W-1:0]            gap_ext;

  assign req.ready = !q_full;
  assign fire      = req.valid && req.ready;

  assign gap_ext     = CMP_W'(min_gap_ticks);
  assign ticks_inc   = (ticks == '1) ? ticks : ticks + 1'b1;
  assign gap_met     = CMP_W'(ticks) >= gap_ext;
  assign gap_met_inc = CMP_W'(ticks_inc) >= gap_ext;

  always_comb begin
    hb_prog_next    = hb_prog;
    ds_prog_next    = ds_prog;
    ticks_next      = ticks;
    held_valid_next = held_valid;
    held_code_next  = held_code;
    push            = 1'b0;
    push_job.kind   = KIND_REFUSED;
    push_job.code   = 8'h00;
    if (fire) begin
      case (req.command)
        CMD_BYTE: begin
          if (hb_prog != 2'd0 || req.rx_byte == HB_B0) begin
            if (hb_prog == 2'd0) begin
              hb_prog_next = 2'd1;
            end else if (hb_prog > 2'd1 || req.rx_byte == HB_B1) begin
              if (hb_prog == 2'd1) begin
                hb_prog_next = 2'd2;
              end else if (req.rx_byte == HB_B2) begin
                hb_prog_next  = 2'd0;
                push          = 1'b1;
                push_job.kind = KIND_HEARTBEAT;
              end
            end else begin
              hb_prog_next = 2'd0;
            end
          end else if (ds_prog != 2'd0 || req.rx_byte == DS_B0) begin
            if (ds_prog == 2'd0) begin
              ds_prog_next = 2'd1;
            end else if (ds_prog > 2'd1 || req.rx_byte == DS_B1) begin
              if (ds_prog == 2'd1) begin
                ds_prog_next = 2'd2;
              end else if (ds_prog > 2'd2 || req.rx_byte == DS_B2) begin
                if (ds_prog == 2'd2) begin
                  ds_prog_next = 2'd3;
                end else if (req.rx_byte == DS_B2) begin
                  ds_prog_next  = 2'd0;
                  push          = 1'b1;
                  push_job.kind = KIND_DESCRIPTOR;
                end
              end
            end else begin
              ds_prog_next = 2'd0;
            end
          end else begin
            hb_prog_next = 2'd0;
            ds_prog_next = 2'd0;
          end
        end
        CMD_REQUEST: begin
          if (held_valid) begin
            push          = 1'b1;
            push_job.kind = KIND_REFUSED;
          end else if (gap_met) begin
            push          = 1'b1;
            push_job.kind = KIND_FRAME;
            push_job.code = req.camera_code;
            ticks_next    = '0;
          end else begin
            held_valid_next = 1'b1;
            held_code_next  = req.camera_code;
          end
        end
        CMD_TICK: begin
          ticks_next = ticks_inc;
          if (held_valid && gap_met_inc) begin
            held_valid_next = 1'b0;
            push            = 1'b1;
            push_job.kind   = KIND_FRAME;
            push_job.code   = held_code;
            ticks_next      = '0;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hb_prog    <= 2'd0;
      ds_prog    <= 2'd0;
      ticks      <= '0;
      held_valid <= 1'b0;
    end else begin
      hb_prog    <= hb_prog_next;
      ds_prog    <= ds_prog_next;
      ticks      <= ticks_next;
      held_valid <= held_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    held_code <= held_code_next;
  end

endmodule

// ----- rtl/slrf_queue.sv -----
// Short job queue between the front end and the byte sender.
`timescale 1ns / 1ps
module slrf_queue
  import slrf_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  job_t push_job,
  output logic full,
  input  logic pop,
  output logic nonempty,
  output job_t head
);

  job_t              entries [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;

  assign full     = count == (QPTR_W + 1)'(QDEPTH);
  assign nonempty = count != '0;
  assign head     = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ----- rtl/slrf_back.sv -----
// Back end: expands one job into its reply or frame bytes on the result channel.
`timescale 1ns / 1ps
module slrf_back
  import slrf_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     q_nonempty,
  input  job_t     q_head,
  output logic     pop,
  slrf_rsp_if.source rsp
);

  logic       busy;
  job_t       job;
  logic [1:0] idx;
  logic       is_last;
  logic       fire;

  assign is_last = idx == job_last_idx(job.kind);
  assign fire    = rsp.valid && rsp.ready;
  assign pop     = q_nonempty && (!busy || (fire && is_last));

  assign rsp.valid       = busy;
  assign rsp.tx_byte     = job_byte(job, idx);
  assign rsp.last_of_run = is_last;
  assign rsp.result_kind = job.kind;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx  <= 2'd0;
    end else if (pop) begin
      busy <= 1'b1;
      idx  <= 2'd0;
    end else if (fire) begin
      if (is_last) begin
        busy <= 1'b0;
        idx  <= 2'd0;
      end else begin
        idx <= idx + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      job <= q_head;
    end
  end

endmodule

// ----- rtl/serial_link_responder_framer_unit.sv -----
// Top level of the serial link responder and command framer.
//
// req carries one item per handshake: a received link byte, a command
// request or a one-tick pulse. rsp carries the resulting bytes, with
// last_of_run on the final byte of each run and result_kind naming the run.
// cfg writes min_gap_ticks; it is always ready and resets to 100.
//
// The front end classifies an item in the cycle it is accepted and posts a
// job to a two-entry queue. The sender loads the job from the queue head,
// and the first byte of a run is offered once the sender holds the job.
// The sender then gives one byte per cycle while rsp is ready: 4 bytes for
// a heartbeat or descriptor reply, 3 for a command frame, 1 for a refusal.
// req takes an item every cycle while the queue has room, so items that
// cause no bytes flow at full rate. When rsp stalls, the sender holds one
// job and the queue two more; with the queue full req.ready drops.
// Reset clears the matchers, the tick count, the hold and the queue.
`timescale 1ns / 1ps
module serial_link_responder_framer_unit
  import slrf_pkg::*;
#(
  parameter int GAP_COUNTER_BITS = 16
) (
  input  logic       clk,
  input  logic       rst,
  slrf_req_if.sink   req,
  slrf_rsp_if.source rsp,
  slrf_cfg_if.sink   cfg
);

  logic [15:0] min_gap_ticks;
  logic        q_full;
  logic        q_nonempty;
  logic        push;
  logic        pop;
  job_t        push_job;
  job_t        q_head;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_gap_ticks <= GAP_RESET;
    end else if (cfg.valid && cfg.ready) begin
      min_gap_ticks <= cfg.data;
    end
  end

  slrf_front #(
    .GAP_COUNTER_BITS(GAP_COUNTER_BITS)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .req          (req),
    .min_gap_ticks(min_gap_ticks),
    .q_full       (q_full),
    .push         (push),
    .push_job     (push_job)
  );

  slrf_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .push_job(push_job),
    .full    (q_full),
    .pop     (pop),
    .nonempty(q_nonempty),
    .head    (q_head)
  );

  slrf_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_nonempty(q_nonempty),
    .q_head    (q_head),
    .pop       (pop),
    .rsp       (rsp)
  );

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> !q_full)
    else $error("job pushed into a full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> q_nonempty)
    else $error("job popped from an empty queue");

  a_refusal_shape: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.result_kind == KIND_REFUSED) |-> (rsp.last_of_run && rsp.tx_byte == 8'h00))
    else $error("refusal must be a single zero byte");

  a_gap_reset: assert property (@(posedge clk)
    $fell(rst) |-> min_gap_ticks == GAP_RESET)
    else $error("gap register not at reset value");

endmodule

// ----- test/serial_link_responder_framer_unit_tb.sv -----
// Self-checking testbench for the serial link responder framer: directed rows, then random.
`timescale 1ns / 1ps
module serial_link_responder_framer_unit_tb;
  import slrf_pkg::*;

  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int LIMIT_CYCLES = 100000;
  localparam int SETTLE_CYCLES = 8;
  localparam int LONG_HOLD = 300;
  localparam int MAX_PRINTED = 100;

  typedef struct packed {
    logic [7:0] tx;
    logic       last;
    kind_t      kind;
  } link_byte_t;

  typedef struct packed {
    logic        cfg;
    logic [15:0] gap;
    logic [1:0]  cmd;
    logic [7:0]  rx;
    logic [7:0]  code;
    logic        typed;
    kind_t       kind;
    logic [2:0]  count;
    logic [31:0] bytes;
  } directed_row_t;

  localparam int DIRECTED_ROWS = 27;
  localparam directed_row_t DIRECTED [DIRECTED_ROWS] = '{
    '{1'b0, 16'd0, CMD_BYTE, 8'h60, 8'h00, 1'b0, KIND_HEARTBEAT, 3'd0, 32'h0},
    '{1'b0, 16'd0, CMD_BYTE, 8'h0B, 8'h00, 1'b0, KIND_HEARTBEAT, 3'd0, 32'h0},
    '{1'b0, 16'd0, CMD_BYTE, 8'h6B, 8'h00, 1'b1, KIND_HEARTBEAT, 3'd4, 32'h2C0199EF},
    '{1'b0, 16'd0, CMD_BYTE, 8'hCD, 8'h00, 1'b0, KIND_HEARTBEAT, 3'd0, 32'h0},
    '{1'b0, 16'd0, CMD_BYTE, 8'hA9, 8'h00, 1'b0, KIND_HEARTBEAT, 3'd0, 32'h0},
    '{1'b0, 16'd0, CMD_BYTE, 8'h00, 8'h00, 1'b0, KIND_HEARTBEAT, 3'd0, 32'h0},
    '{1'b0, 16'd0, CMD_BYTE, 8'h00, 8'h00, 1'b1, KIND_DESCRIPTOR, 3'd4, 32'h33011011},
    // early request is held, second one refused
    '{1'b0, 16'd0, CMD_REQUEST, 8'h00, 8'hFF, 1'b1, KIND_FRAME, 3'd0, 32'h0},
    '{1'b0, 16'd0, CMD_REQUEST, 8'h00, 8'h00, 1'b1, KIND_REFUSED, 3'd1, 32'h0},
    '{1'b0, 16'd0, CMD_UNUSED, 8'hFF, 8'hFF, 1'b1, KIND_HEARTBEAT, 3'd0, 32'h0},
    '{1'b0, 16'd0, CMD_TICK, 8'h00, 8'h00, 1'b0, KIND_HEARTBEAT, 3'd0, 32'h0},
    '{1'b1, 16'd0, CMD_BYTE, 8'h00, 8'h00, 1'b0, KIND_HEARTBEAT, 3'd0, 32'h0},
    '{1'b0, 16'd0, CMD_TICK, 8'h00, 8'h00, 1'b1, KIND_FRAME, 3'd3, 32'hACFF5300},
    '{1'b0, 16'd0, CMD_REQUEST, 8'h00, 8'h5A, 1'b1, KIND_FRAME, 3'd3, 32'hAC5AF600},
    // matchers waiting on a stray byte
    '{1'b0, 16'd0, CMD_BYTE, 8'h60, 8'h00, 1'b0, KIND_HEARTBEAT, 3'd0, 32'h0},
    '{1'b0, 16'd0, CMD_BYTE, 8'h0B, 8'h00, 1'b0, KIND_HEARTBEAT, 3'd0, 32'h0},
    '{1'b0, 16'd0, CMD_BYTE, 8'h12, 8'h00, 1'b0, KIND_HEARTBEAT, 3'd0, 32'h0},
    '{1'b0, 16'd0, CMD_BYTE, 8'h6B, 8'h00, 1'b0, KIND_HEARTBEAT, 3'd0, 32'h0},
    '{1'b0, 16'd0, CMD_BYTE, 8'hCD, 8'h00, 1'b0, KIND_HEARTBEAT, 3'd0, 32'h0},
    '{1'b0, 16'd0, CMD_BYTE, 8'hA9, 8'h00, 1'b0, KIND_HEARTBEAT, 3'd0, 32'h0},
    '{1'b0, 16'd0, CMD_BYTE, 8'h7E, 8'h00, 1'b0, KIND_HEARTBEAT, 3'd0, 32'h0},
    '{1'b0, 16'd0, CMD_BYTE, 8'h00, 8'h00, 1'b0, KIND_HEARTBEAT, 3'd0, 32'h0},
    '{1'b0, 16'd0, CMD_BYTE, 8'h00, 8'h00, 1'b0, KIND_HEARTBEAT, 3'd0, 32'h0},
    '{1'b1, 16'hFFFF, CMD_BYTE, 8'h00, 8'h00, 1'b0, KIND_HEARTBEAT, 3'd0, 32'h0},
    '{1'b0, 16'd0, CMD_REQUEST, 8'h00, 8'h81, 1'b0, KIND_HEARTBEAT, 3'd0, 32'h0},
    '{1'b0, 16'd0, CMD_REQUEST, 8'h00, 8'h01, 1'b1, KIND_REFUSED, 3'd1, 32'h0},
    '{1'b0, 16'd0, CMD_TICK, 8'h00, 8'h00, 1'b0, KIND_HEARTBEAT, 3'd0, 32'h0}
  };

  logic clk;
  logic rst;

  slrf_req_if req ();
  slrf_rsp_if rsp ();
  slrf_cfg_if cfg ();

  serial_link_responder_framer_unit DUT (
    .clk(clk),
    .rst(rst),
    .req(req),
    .rsp(rsp),
    .cfg(cfg)
  );

  // predictor state
  logic [15:0] gap_ticks;
  logic [1:0]  hb_prog;
  logic [1:0]  ds_prog;
  logic [15:0] ticks_since;
  logic        hold_pending;
  logic [7:0]  hold_code;

  link_byte_t tx_expected[$];
  link_byte_t want;

  logic        use_typed;
  kind_t       typed_kind;
  logic [2:0]  typed_count;
  logic [31:0] typed_bytes;

  int mismatch_count;
  int items_sent;
  int gap_writes;
  int kind_seen [4];
  int cycle_count;
  int burst_left;
  bit no_idle;
  int hold_off_asked;
  int hold_off_seen;
  int hold_off_left;
  logic [15:0] stall_pattern;
  int pat_pos;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  task automatic note_mismatch(input string what);
    mismatch_count++;
    if (mismatch_count <= MAX_PRINTED) $display("MISMATCH @%0t: %s", $realtime, what);
  endtask

  // queue a run of n bytes taken from the top of bytes
  task automatic stage_run(input kind_t kind, input logic [31:0] bytes, input int n);
    link_byte_t entry;
    int i;
    if (use_typed) return;
    for (i = 0; i < n; i++) begin
      entry.tx = bytes[31 - 8 * i -: 8];
      entry.last = (i == n - 1);
      entry.kind = kind;
      tx_expected.push_back(entry);
    end
  endtask

  task automatic stage_frame(input logic [7:0] code);
    stage_run(KIND_FRAME, {FRAME_SYNC, code, FRAME_SYNC ^ code, 8'h00}, 3);
    ticks_since = '0;
  endtask

  task automatic predict_link_item(input logic [1:0] cmd, input logic [7:0] rx,
                                   input logic [7:0] code);
    case (cmd)
      CMD_BYTE: begin
        if (hb_prog != 2'd0 || rx == HB_B0) begin
          if (hb_prog == 2'd0) hb_prog = 2'd1;
          else if (hb_prog > 2'd1 || rx == HB_B1) begin
            if (hb_prog == 2'd1) hb_prog = 2'd2;
            else if (rx == HB_B2) begin
              hb_prog = 2'd0;
              stage_run(KIND_HEARTBEAT, 32'h2C0199EF, 4);
            end
          end else hb_prog = 2'd0;
        end else if (ds_prog != 2'd0 || rx == DS_B0) begin
          if (ds_prog == 2'd0) ds_prog = 2'd1;
          else if (ds_prog > 2'd1 || rx == DS_B1) begin
            if (ds_prog == 2'd1) ds_prog = 2'd2;
            else if (ds_prog > 2'd2 || rx == DS_B2) begin
              if (ds_prog == 2'd2) ds_prog = 2'd3;
              else if (rx == DS_B2) begin
                ds_prog = 2'd0;
                stage_run(KIND_DESCRIPTOR, 32'h33011011, 4);
              end
            end
          end else ds_prog = 2'd0;
        end else begin
          hb_prog = 2'd0;
          ds_prog = 2'd0;
        end
      end
      CMD_REQUEST: begin
        if (hold_pending) stage_run(KIND_REFUSED, 32'h0, 1);
        else if (ticks_since >= gap_ticks) stage_frame(code);
        else begin
          hold_pending = 1'b1;
          hold_code = code;
        end
      end
      CMD_TICK: begin
        if (ticks_since != 16'hFFFF) ticks_since++;
        if (hold_pending && ticks_since >= gap_ticks) begin
          hold_pending = 1'b0;
          stage_frame(hold_code);
        end
      end
      default: ;
    endcase
  endtask

  task automatic offer_item(input logic [1:0] cmd, input logic [7:0] rx,
                            input logic [7:0] code);
    int idle_cycles;
    if (burst_left == 0 && !no_idle) begin
      burst_left = $urandom_range(1, 12);
      idle_cycles = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (idle_cycles > 0) begin
        req.valid <= 1'b0;
        repeat (idle_cycles) @(posedge clk);
      end
    end
    if (burst_left > 0) burst_left--;
    req.valid <= 1'b1;
    req.command <= cmd;
    req.rx_byte <= rx;
    req.camera_code <= code;
    do @(posedge clk); while (!req.ready);
    items_sent++;
    predict_link_item(cmd, rx, code);
    if (use_typed) begin
      use_typed = 1'b0;
      stage_run(typed_kind, typed_bytes, int'(typed_count));
    end
  endtask

  task automatic wait_quiet();
    req.valid <= 1'b0;
    burst_left = 0;
    while (tx_expected.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_gap(input logic [15:0] value);
    wait_quiet();
    cfg.valid <= 1'b1;
    cfg.data <= value;
    do @(posedge clk); while (!cfg.ready);
    cfg.valid <= 1'b0;
    gap_ticks = value;
    gap_writes++;
  endtask

  task automatic offer_random_traffic(input int target);
    int first_item;
    int pick;
    first_item = items_sent;
    while (items_sent - first_item < target) begin
      pick = $urandom_range(0, 99);
      if (pick < 28) begin
        offer_item(CMD_BYTE, HB_B0, 8'($urandom));
        offer_item(CMD_BYTE, HB_B1, 8'($urandom));
        repeat ($urandom_range(0, 2)) offer_item(CMD_BYTE, 8'($urandom), 8'($urandom));
        offer_item(CMD_BYTE, HB_B2, 8'($urandom));
      end else if (pick < 50) begin
        offer_item(CMD_BYTE, DS_B0, 8'($urandom));
        offer_item(CMD_BYTE, DS_B1, 8'($urandom));
        repeat ($urandom_range(0, 1))
          offer_item(CMD_BYTE, 8'($urandom_range(1, 255)), 8'($urandom));
        offer_item(CMD_BYTE, DS_B2, 8'($urandom));
        repeat ($urandom_range(0, 1))
          offer_item(CMD_BYTE, 8'($urandom_range(1, 255)), 8'($urandom));
        offer_item(CMD_BYTE, DS_B2, 8'($urandom));
      end else if (pick < 72) begin
        offer_item(CMD_REQUEST, 8'($urandom), 8'($urandom));
      end else if (pick < 88) begin
        repeat ($urandom_range(1, 4)) offer_item(CMD_TICK, 8'($urandom), 8'($urandom));
      end else if (pick < 93) begin
        offer_item(CMD_BYTE, 8'($urandom), 8'($urandom));
      end else if (pick < 97) begin
        // sequence broken after its first byte
        offer_item(CMD_BYTE, $urandom_range(0, 1) ? HB_B0 : DS_B0, 8'($urandom));
        offer_item(CMD_BYTE, 8'($urandom), 8'($urandom));
      end else begin
        offer_item(CMD_UNUSED, 8'($urandom), 8'($urandom));
      end
    end
  endtask

  // result side: check, then pick next ready from the stall pattern
  always @(posedge clk) begin
    if (rst) begin
      rsp.ready <= 1'b0;
      pat_pos = 0;
    end else begin
      if (rsp.valid && rsp.ready) begin
        kind_seen[rsp.result_kind]++;
        if (tx_expected.size() == 0) begin
          note_mismatch($sformatf("unexpected byte %h kind %0d", rsp.tx_byte,
                                  rsp.result_kind));
        end else begin
          want = tx_expected.pop_front();
          if (rsp.tx_byte !== want.tx)
            note_mismatch($sformatf("tx_byte %h, want %h", rsp.tx_byte, want.tx));
          if (rsp.last_of_run !== want.last)
            note_mismatch($sformatf("last_of_run %b, want %b", rsp.last_of_run, want.last));
          if (rsp.result_kind !== want.kind)
            note_mismatch($sformatf("result_kind %0d, want %0d", rsp.result_kind,
                                    want.kind));
        end
      end
      if (hold_off_seen != hold_off_asked) begin
        hold_off_seen = hold_off_asked;
        hold_off_left = LONG_HOLD;
      end
      if (hold_off_left > 0) begin
        hold_off_left--;
        rsp.ready <= 1'b0;
      end else begin
        if (pat_pos == 0) begin
          case ($urandom_range(0, 3))
            0: stall_pattern = 16'hFFFF;
            1: stall_pattern = 16'($urandom | $urandom);
            2: stall_pattern = 16'($urandom);
            default: stall_pattern = 16'($urandom & $urandom);
          endcase
        end
        rsp.ready <= stall_pattern[pat_pos];
        pat_pos = (pat_pos + 1) % 16;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("timeout after %0d cycles, %0d bytes still due", cycle_count,
               tx_expected.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin : stimulus
    int row;
    rst <= 1'b1;
    req.valid <= 1'b0;
    req.command <= CMD_BYTE;
    req.rx_byte <= 8'h00;
    req.camera_code <= 8'h00;
    cfg.valid <= 1'b0;
    cfg.data <= 16'h0000;
    gap_ticks = GAP_RESET;
    hb_prog = 2'd0;
    ds_prog = 2'd0;
    ticks_since = '0;
    hold_pending = 1'b0;
    hold_code = 8'h00;
    use_typed = 1'b0;
    no_idle = 1'b0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (row = 0; row < DIRECTED_ROWS; row++) begin
      if (DIRECTED[row].cfg) set_gap(DIRECTED[row].gap);
      else begin
        use_typed = DIRECTED[row].typed;
        typed_kind = DIRECTED[row].kind;
        typed_count = DIRECTED[row].count;
        typed_bytes = DIRECTED[row].bytes;
        offer_item(DIRECTED[row].cmd, DIRECTED[row].rx, DIRECTED[row].code);
      end
    end

    set_gap(16'd2);
    offer_random_traffic(20);

    // long output stall while replies keep coming in
    hold_off_asked++;
    no_idle = 1'b1;
    repeat (5) begin
      offer_item(CMD_BYTE, HB_B0, 8'($urandom));
      offer_item(CMD_BYTE, HB_B1, 8'($urandom));
      offer_item(CMD_BYTE, HB_B2, 8'($urandom));
    end
    no_idle = 1'b0;
    offer_random_traffic(8);
    wait_quiet();
    offer_random_traffic(8);

    // drop any hold, then frames back to back with no gap
    set_gap(16'd0);
    offer_item(CMD_TICK, 8'($urandom), 8'($urandom));
    no_idle = 1'b1;
    repeat (3) offer_item(CMD_REQUEST, 8'($urandom), 8'($urandom));
    no_idle = 1'b0;

    set_gap(16'($urandom_range(3, 9)));
    offer_random_traffic(18);
    set_gap(GAP_RESET);
    offer_random_traffic(12);

    wait_quiet();
    repeat (16) @(posedge clk);
    $display("covered %0d items over %0d gap settings incl. 0 and 65535, a long output stall",
             items_sent, gap_writes);
    $display("bytes checked: heartbeat %0d, descriptor %0d, frame %0d, refused %0d",
             kind_seen[KIND_HEARTBEAT], kind_seen[KIND_DESCRIPTOR], kind_seen[KIND_FRAME],
             kind_seen[KIND_REFUSED]);
    if (mismatch_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
